[src/abhp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abhp_pkg
// Shared types, status codes and flag decode helpers for the audio block
// header parser.
// ----------------------------------------------------------------------------
package abhp_pkg;

    // Status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_FLAG    = 3'd1;
    localparam logic [2:0] ST_BAD_COMP    = 3'd2;
    localparam logic [2:0] ST_BAD_CHANNEL = 3'd3;
    localparam logic [2:0] ST_COUNT_MISM  = 3'd4;
    localparam logic [2:0] ST_TOO_BIG     = 3'd5;
    localparam logic [2:0] ST_TOO_SMALL   = 3'd6;
    localparam logic [2:0] ST_NO_BODY     = 3'd7;

    localparam logic [7:0]  COMP_MIN     = 8'd5;
    localparam logic [7:0]  COMP_MAX     = 8'd7;
    localparam logic [31:0] COUNT_MASK   = 32'h0FFF_FFFF;
    localparam logic [31:0] BLOCK_HDR    = 32'd8;
    localparam logic [4:0]  FLAG_END_POS = 5'd7;
    localparam logic [4:0]  EXTRA_POS    = 5'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } abhp_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        parser_kind;
        logic [7:0]  compression;
        logic [6:0]  channels;
        logic [15:0] sample_rate;
        logic [3:0]  flag_bits;
        logic [31:0] total_samples;
        logic [31:0] payload_size;
        logic [4:0]  header_length;
    } abhp_out_t;

    // Fields of one finished header
    typedef struct packed {
        logic [7:0]  compression;
        logic [7:0]  channel_byte;
        logic [15:0] sample_rate;
        logic [3:0]  flags;
        logic [31:0] count_first;
        logic [31:0] block_size;
        logic [31:0] count_second;
    } abhp_hdr_t;

    // Extra word follows: bit 1 branch or bit 3 branch
    function automatic logic has_extra(input logic [3:0] f);
        logic r;
        begin
            if (f == 4'd0 || f[0]) r = 1'b0;
            else if (f[1])         r = 1'b1;
            else if (f[2])         r = 1'b0;
            else                   r = f[3];
            return r;
        end
    endfunction

    function automatic logic has_body(input logic [3:0] f);
        return !f[2];
    endfunction

    function automatic logic [4:0] header_len(input logic [3:0] f);
        logic [4:0] n;
        begin
            n = 5'd8;
            if (has_extra(f)) n = n + 5'd4;
            if (has_body(f))  n = n + 5'd8;
            return n;
        end
    endfunction

    function automatic logic [31:0] shift_in(input logic [31:0] acc,
                                             input logic [7:0]  b);
        return {acc[23:0], b};
    endfunction

endpackage

[src/abhp_assembler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abhp_assembler
// Byte position tracking and field assembly; flags a finished header.
// ----------------------------------------------------------------------------
module abhp_assembler (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  abhp_pkg::abhp_in_t s_data,
    input  logic               res_free,
    output logic               done,
    output abhp_pkg::abhp_hdr_t hdr
);
    import abhp_pkg::*;

    logic [4:0]  idx_reg, idx_next;
    logic        active_reg, active_next;
    logic        done_reg, done_next;
    logic [7:0]  comp_reg, comp_next;
    logic [7:0]  chan_reg, chan_next;
    logic [15:0] rate_reg, rate_next;
    logic [31:0] flag_reg, flag_next;
    logic [31:0] cnt1_reg, cnt1_next;
    logic [31:0] blk_reg, blk_next;
    logic [31:0] cnt2_reg, cnt2_next;

    logic        accept;
    logic        active_eff;
    logic [4:0]  pos;
    logic [4:0]  pos_inc;
    logic [4:0]  rel;
    logic        skip;
    logic [3:0]  f_old;
    logic [3:0]  f_new;
    logic [7:0]  b;

    // Stage holds while a finished header waits for the result register
    assign s_ready = !done_reg || res_free;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.data_byte;

    always_comb begin
        idx_next    = idx_reg;
        active_next = active_reg;
        done_next   = done_reg && !res_free;
        comp_next   = comp_reg;
        chan_next   = chan_reg;
        rate_next   = rate_reg;
        flag_next   = flag_reg;
        cnt1_next   = cnt1_reg;
        blk_next    = blk_reg;
        cnt2_next   = cnt2_reg;
        active_eff  = active_reg || s_data.first_byte;
        pos         = s_data.first_byte ? 5'd0 : idx_reg;
        pos_inc     = pos + 5'd1;
        rel         = pos - EXTRA_POS;
        skip        = 1'b0;
        f_old       = flag_reg[31:28];
        f_new       = flag_reg[31:28];

        if (accept && active_eff) begin
            if (pos == 5'd0) begin
                comp_next = b;
            end else if (pos == 5'd1) begin
                chan_next = b;
            end else if (pos <= 5'd3) begin
                rate_next = {rate_reg[7:0], b};
            end else if (pos <= FLAG_END_POS) begin
                flag_next = shift_in(flag_reg, b);
                if (pos == FLAG_END_POS) begin
                    priority if (flag_next[31:28] == 4'd0) begin
                        cnt1_next = flag_next;
                    end else if (flag_next[28]) begin
                        cnt1_next = '0;
                    end else if (flag_next[29]) begin
                        cnt1_next = flag_next & COUNT_MASK;
                    end else begin
                        cnt1_next = '0;
                    end
                    blk_next  = '0;
                    cnt2_next = '0;
                end
            end else begin
                if (has_extra(f_old)) begin
                    if (rel < 5'd4) begin
                        if (!f_old[1]) cnt1_next = shift_in(cnt1_reg, b);
                        skip = 1'b1;
                    end else begin
                        rel = rel - 5'd4;
                    end
                end
                if (!skip && has_body(f_old)) begin
                    if (rel < 5'd4)      blk_next  = shift_in(blk_reg, b);
                    else if (rel < 5'd8) cnt2_next = shift_in(cnt2_reg, b);
                end
            end

            f_new = flag_next[31:28];
            if (pos >= FLAG_END_POS && pos_inc >= header_len(f_new)) begin
                done_next   = 1'b1;
                active_next = 1'b0;
                idx_next    = '0;
            end else begin
                active_next = 1'b1;
                idx_next    = pos_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            idx_reg    <= idx_next;
            active_reg <= active_next;
            done_reg   <= done_next;
        end
        comp_reg <= comp_next;
        chan_reg <= chan_next;
        rate_reg <= rate_next;
        flag_reg <= flag_next;
        cnt1_reg <= cnt1_next;
        blk_reg  <= blk_next;
        cnt2_reg <= cnt2_next;
    end

    assign done             = done_reg;
    assign hdr.compression  = comp_reg;
    assign hdr.channel_byte = chan_reg;
    assign hdr.sample_rate  = rate_reg;
    assign hdr.flags        = flag_reg[31:28];
    assign hdr.count_first  = cnt1_reg;
    assign hdr.block_size   = blk_reg;
    assign hdr.count_second = cnt2_reg;

endmodule

[src/abhp_result.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abhp_result
// Header validation and decode into the output register.
// ----------------------------------------------------------------------------
module abhp_result (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                done,
    input  abhp_pkg::abhp_hdr_t hdr,
    input  logic [31:0]         stream_length,
    output logic                res_free,
    output logic                m_valid,
    input  logic                m_ready,
    output abhp_pkg::abhp_out_t m_data
);
    import abhp_pkg::*;

    logic      m_valid_reg, m_valid_next;
    abhp_out_t out_reg, out_next;
    logic [32:0] need;
    logic        body;
    logic        undersize;

    assign res_free = !m_valid_reg || m_ready;

    always_comb begin
        need      = {1'b0, hdr.block_size} + {1'b0, BLOCK_HDR};
        body      = has_body(hdr.flags);
        undersize = hdr.block_size < BLOCK_HDR;

        priority if (hdr.flags != 4'd0 && hdr.flags[0]) begin
            out_next.status = ST_BAD_FLAG;
        end else if (hdr.compression < COMP_MIN || hdr.compression > COMP_MAX) begin
            out_next.status = ST_BAD_COMP;
        end else if (hdr.channel_byte[1:0] != 2'd0) begin
            out_next.status = ST_BAD_CHANNEL;
        end else if (hdr.count_first != hdr.count_second) begin
            out_next.status = ST_COUNT_MISM;
        end else if (need > {1'b0, stream_length}) begin
            out_next.status = ST_TOO_BIG;
        end else if (!body) begin
            out_next.status = ST_NO_BODY;
        end else if (undersize) begin
            out_next.status = ST_TOO_SMALL;
        end else begin
            out_next.status = ST_OK;
        end

        out_next.parser_kind   = (hdr.compression == 8'd6) || (hdr.compression == COMP_MAX);
        out_next.compression   = hdr.compression;
        out_next.channels      = {1'b0, hdr.channel_byte[7:2]} + 7'd1;
        out_next.sample_rate   = hdr.sample_rate;
        out_next.flag_bits     = hdr.flags;
        out_next.total_samples = hdr.count_first;
        out_next.payload_size  = (body && !undersize) ? hdr.block_size - BLOCK_HDR : 32'd0;
        out_next.header_length = header_len(hdr.flags);

        m_valid_next = m_valid_reg && !m_ready;
        if (done && res_free) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (done && res_free) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

[src/audio_block_header_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_block_header_parser
// Parses audio block headers arriving one byte per item and emits one
// decoded, validated result item per header.
// ----------------------------------------------------------------------------
// One header byte is taken per item, one per clock when both sides keep up.
// An item with first_byte set starts a new header, dropping any partial one;
// bytes outside a header are ignored. Bytes 0 to 7 carry compression,
// channel byte, big-endian sample rate and the big-endian flags-and-value
// word; its top four flag bits choose an optional extra word and an optional
// 8-byte body (block size, second sample count), giving 8, 12, 16 or 20
// bytes. Once the last byte is in, the header fields sit in the assembler
// registers until the output register is free; the decode and status checks
// are then loaded into the output register and m_valid rises. The only
// stall is when a finished header finds the output register still full:
// s_ready then follows m_ready. stream_length (reset all ones) bounds block
// size plus 8; write it only while idle. cfg_ready is always high.
// ----------------------------------------------------------------------------
module audio_block_header_parser (
    input  logic                aclk,
    input  logic                aresetn,
    // byte input
    input  logic                s_valid,
    output logic                s_ready,
    input  abhp_pkg::abhp_in_t  s_data,
    // result output
    output logic                m_valid,
    input  logic                m_ready,
    output abhp_pkg::abhp_out_t m_data,
    // stream_length register write
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_data
);
    import abhp_pkg::*;

    logic [31:0] stream_len_reg;
    logic        res_free;
    logic        done;
    abhp_hdr_t   hdr;

    assign cfg_ready = 1'b1;

    // Stream length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stream_len_reg <= 32'hFFFF_FFFF;
        end else if (cfg_valid) begin
            stream_len_reg <= cfg_data;
        end
    end

    // Byte position tracking and field assembly
    abhp_assembler u_assembler (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .res_free (res_free),
        .done     (done),
        .hdr      (hdr)
    );

    // Validation, decode and output register
    abhp_result u_result (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .done          (done),
        .hdr           (hdr),
        .stream_length (stream_len_reg),
        .res_free      (res_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

endmodule
